FILE: hw/rtl/csfb_pkg.sv
package csfb_pkg;

  // item codes
  localparam logic FuncStart   = 1'b0;
  localparam logic FuncPayload = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIndexWidth = 8;
  localparam logic [CfgIndexWidth-1:0] CfgMasterId = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CfgSlaveId  = 8'd1;

  // crc-16/modbus constants
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // default depth of the command queue
  localparam int unsigned CmdQueueDepth = 4;

  // command handed from the front to the back
  typedef struct packed {
    logic       is_data;  // payload byte, else frame header
    logic       close;    // crc follows this command
    logic [7:0] b_hi;     // header: state/length byte, data: payload byte
    logic [7:0] b_lo;     // header: rw/command byte
  } cmd_t;

  // one byte step of the reflected crc
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/csfb_front.sv
module csfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              func_i,
  input  logic              state_bit_i,
  input  logic [6:0]        length_field_i,
  input  logic              rw_bit_i,
  input  logic [6:0]        command_i,
  input  logic [7:0]        payload_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output csfb_pkg::cmd_t    q_cmd_o
);

  logic       open_q, open_d;
  logic [6:0] left_q, left_d;
  logic       accept;
  logic       start_close;
  logic       data_last;

  assign full_o      = q_full_i;
  assign accept      = push_i && !q_full_i;
  assign start_close = (length_field_i <= 7'd1);
  assign data_last   = (left_q == 7'd1);

  // classify the item and build the command
  always_comb begin
    q_push_o = 1'b0;
    q_cmd_o  = '0;
    open_d   = open_q;
    left_d   = left_q;
    if (accept) begin
      if (func_i == csfb_pkg::FuncStart) begin
        q_push_o        = 1'b1;
        q_cmd_o.is_data = 1'b0;
        q_cmd_o.close   = start_close;
        q_cmd_o.b_hi    = {state_bit_i, length_field_i};
        q_cmd_o.b_lo    = {rw_bit_i, command_i};
        open_d          = !start_close;
        left_d          = start_close ? 7'd0 : (length_field_i - 7'd1);
      end else if (open_q) begin
        q_push_o        = 1'b1;
        q_cmd_o.is_data = 1'b1;
        q_cmd_o.close   = data_last;
        q_cmd_o.b_hi    = payload_byte_i;
        q_cmd_o.b_lo    = 8'h00;
        open_d          = !data_last;
        left_d          = left_q - 7'd1;
      end
    end
  end

  // frame tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

`ifndef SYNTHESIS
  a_open_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (left_q != 7'd0))
    else $error("open frame with no bytes left");
`endif

endmodule

FILE: hw/rtl/csfb_cmdq.sv
module csfb_cmdq #(
  parameter int unsigned Depth = csfb_pkg::CmdQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  csfb_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output csfb_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  csfb_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/csfb_back.sv
module csfb_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [csfb_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [7:0]                           cfg_data_i,
  input  logic                                 q_valid_i,
  input  csfb_pkg::cmd_t                       q_head_i,
  output logic                                 q_pop_o,
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output logic [7:0]                           tx_byte_o,
  output logic                                 frame_end_o
);

  // byte roles within a command
  localparam logic [2:0] RMaster = 3'd0;
  localparam logic [2:0] RSlave  = 3'd1;
  localparam logic [2:0] RHdr2   = 3'd2;
  localparam logic [2:0] RHdr3   = 3'd3;
  localparam logic [2:0] RData   = 3'd4;
  localparam logic [2:0] RCrcHi  = 3'd5;
  localparam logic [2:0] RCrcLo  = 3'd6;

  logic [7:0]  master_q, slave_q;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  step_q;
  logic [2:0]  role;
  logic [7:0]  byte_sel;
  logic        last_step;
  logic        out_valid_q;
  logic [7:0]  tx_q;
  logic        end_q;
  logic        advance;

  assign empty_o     = !out_valid_q;
  assign tx_byte_o   = tx_q;
  assign frame_end_o = end_q;
  assign advance     = q_valid_i && (!out_valid_q || pop_i);
  assign q_pop_o     = advance && last_step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= '0;
      slave_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == csfb_pkg::CfgMasterId) begin
        master_q <= cfg_data_i;
      end else if (cfg_index_i == csfb_pkg::CfgSlaveId) begin
        slave_q <= cfg_data_i;
      end
    end
  end

  // role of the byte at this step
  always_comb begin
    if (q_head_i.is_data) begin
      case (step_q)
        3'd0:    role = RData;
        3'd1:    role = RCrcHi;
        default: role = RCrcLo;
      endcase
    end else begin
      case (step_q)
        3'd0:    role = RMaster;
        3'd1:    role = RSlave;
        3'd2:    role = RHdr2;
        3'd3:    role = RHdr3;
        3'd4:    role = RCrcHi;
        default: role = RCrcLo;
      endcase
    end
  end

  // byte select and crc update
  always_comb begin
    byte_sel  = 8'h00;
    crc_d     = crc_q;
    last_step = 1'b0;
    unique case (role)
      RMaster: begin
        byte_sel = master_q;
        crc_d    = csfb_pkg::crc_byte(csfb_pkg::CrcInit, master_q);
      end
      RSlave: begin
        byte_sel = slave_q;
        crc_d    = csfb_pkg::crc_byte(crc_q, slave_q);
      end
      RHdr2: begin
        byte_sel = q_head_i.b_hi;
        crc_d    = csfb_pkg::crc_byte(crc_q, q_head_i.b_hi);
      end
      RHdr3: begin
        byte_sel  = q_head_i.b_lo;
        crc_d     = csfb_pkg::crc_byte(crc_q, q_head_i.b_lo);
        last_step = !q_head_i.close;
      end
      RData: begin
        byte_sel  = q_head_i.b_hi;
        crc_d     = csfb_pkg::crc_byte(crc_q, q_head_i.b_hi);
        last_step = !q_head_i.close;
      end
      RCrcHi: begin
        byte_sel = crc_q[15:8];
      end
      RCrcLo: begin
        byte_sel  = crc_q[7:0];
        crc_d     = csfb_pkg::CrcInit;
        last_step = 1'b1;
      end
      default: begin
        byte_sel = 8'h00;
      end
    endcase
  end

  // sequencer and crc state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      crc_q  <= csfb_pkg::CrcInit;
    end else if (advance) begin
      step_q <= last_step ? 3'd0 : step_q + 3'd1;
      crc_q  <= crc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tx_q  <= byte_sel;
      end_q <= (role == RCrcLo);
    end
  end

`ifndef SYNTHESIS
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid_i |-> (step_q == 3'd0))
    else $error("sequencer left mid command with empty queue");
  a_data_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_head_i.is_data) |-> (step_q <= 3'd2))
    else $error("payload command step out of range");
  a_crc_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (role == RCrcLo)) |=> (crc_q == csfb_pkg::CrcInit) && end_q)
    else $error("crc not reinitialized after frame end");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (step_q == 3'd0))
    else $error("command popped before its last byte");
`endif

endmodule

FILE: hw/rtl/crc16_serial_frame_builder.sv
// items pass the command queue and output register; throughput: one payload item per cycle
// while the queue has room and bytes are popped; a start item occupies the output for 4 bytes,
// 6 when its length is 0 or 1, and a closing payload item for 3, set by the output register
// a 4-entry command queue lets the input side keep taking items during header and crc bursts
// reset: asynchronous active low; empties the queue, closes any frame, crc to 0xffff, ids to 0
module crc16_serial_frame_builder #(
  parameter int unsigned QueueDepth = csfb_pkg::CmdQueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [csfb_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic                               func_i,
  input  logic                               state_bit_i,
  input  logic [6:0]                         length_field_i,
  input  logic                               rw_bit_i,
  input  logic [6:0]                         command_i,
  input  logic [7:0]                         payload_byte_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [7:0]                         tx_byte_o,
  output logic                               frame_end_o
);

  logic           q_full, q_push, q_valid, q_pop;
  csfb_pkg::cmd_t q_cmd, q_head;

  assign cfg_ready_o = 1'b1;

  // front: accept and classify items
  csfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .func_i         (func_i),
    .state_bit_i    (state_bit_i),
    .length_field_i (length_field_i),
    .rw_bit_i       (rw_bit_i),
    .command_i      (command_i),
    .payload_byte_i (payload_byte_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (q_cmd)
  );

  // command queue between front and back
  csfb_cmdq #(
    .Depth (QueueDepth)
  ) u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // back: byte sequencer, crc and output register
  csfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .tx_byte_o   (tx_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  // register indexes that map to no register
  localparam logic [csfb_pkg::CfgIndexWidth-1:0] CfgUnusedLow  = 8'd2;
  localparam logic [csfb_pkg::CfgIndexWidth-1:0] CfgUnusedHigh = 8'hFF;

  // receiver hold-off length used to back up the block
  localparam int HoldOffCycles = 200;

  typedef struct {
    logic       func;
    logic       st;
    logic [6:0] len;
    logic       rw;
    logic [6:0] cmd;
    logic [7:0] data;
  } host_item_t;

  typedef struct {
    logic [7:0] tx;
    logic       last;
  } tx_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [csfb_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [7:0]                         cfg_data = '0;

  logic       push = 1'b0;
  logic       full;
  logic       func = csfb_pkg::FuncStart;
  logic       state_bit = 1'b0;
  logic [6:0] length_field = '0;
  logic       rw_bit = 1'b0;
  logic [6:0] command = '0;
  logic [7:0] payload_byte = '0;

  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] tx_byte;
  logic       frame_end;

  // stimulus and expected stream
  host_item_t host_items_q[$];
  tx_byte_t   due_bytes_q[$];

  // predictor state
  logic [7:0]  master_id_m = 8'h00;
  logic [7:0]  slave_id_m = 8'h00;
  logic [15:0] crc_run = csfb_pkg::CrcInit;
  logic [6:0]  bytes_left = '0;
  logic        frame_open = 1'b0;

  // phase knobs
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_on = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int mismatch_cnt = 0;
  int n_frames = 0;
  int n_bytes = 0;
  int n_dropped = 0;
  int n_reg_writes = 0;
  tx_byte_t want;

  crc16_serial_frame_builder u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push_i         (push),
    .full_o         (full),
    .func_i         (func),
    .state_bit_i    (state_bit),
    .length_field_i (length_field),
    .rw_bit_i       (rw_bit),
    .command_i      (command),
    .payload_byte_i (payload_byte),
    .empty_o        (empty),
    .pop_i          (pop),
    .tx_byte_o      (tx_byte),
    .frame_end_o    (frame_end)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // reflected crc-16, one byte
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ csfb_pkg::CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic void emit_data_byte(logic [7:0] b);
    crc_run = crc16_modbus_step(crc_run, b);
    due_bytes_q.push_back('{tx: b, last: 1'b0});
  endfunction

  function automatic void emit_crc_trailer();
    due_bytes_q.push_back('{tx: crc_run[15:8], last: 1'b0});
    due_bytes_q.push_back('{tx: crc_run[7:0], last: 1'b1});
    crc_run = csfb_pkg::CrcInit;
    frame_open = 1'b0;
    bytes_left = '0;
  endfunction

  // expected frame bytes caused by one accepted item
  function automatic void build_frame_bytes(host_item_t it);
    if (it.func == csfb_pkg::FuncStart) begin
      crc_run = csfb_pkg::CrcInit;
      emit_data_byte(master_id_m);
      emit_data_byte(slave_id_m);
      emit_data_byte({it.st, it.len});
      emit_data_byte({it.rw, it.cmd});
      if (it.len <= 7'd1) begin
        emit_crc_trailer();
      end else begin
        bytes_left = it.len - 7'd1;
        frame_open = 1'b1;
      end
    end else if (!frame_open) begin
      n_dropped++;
    end else begin
      emit_data_byte(it.data);
      bytes_left = bytes_left - 7'd1;
      if (bytes_left == 7'd0) emit_crc_trailer();
    end
  endfunction

  // item sender
  always @(negedge clk) begin
    if (rst_n && host_items_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      func <= host_items_q[0].func;
      state_bit <= host_items_q[0].st;
      length_field <= host_items_q[0].len;
      rw_bit <= host_items_q[0].rw;
      command <= host_items_q[0].cmd;
      payload_byte <= host_items_q[0].data;
    end else begin
      push <= 1'b0;
    end
  end

  // accepted items feed the predictor
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      build_frame_bytes(host_items_q.pop_front());
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_done <= 1'b1;
    end else if (pressure_on && !hold_done) begin
      pop <= 1'b0;
      hold_left <= HoldOffCycles;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each popped byte with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      n_bytes++;
      if (frame_end) n_frames++;
      if (due_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none actual tx_byte %02h frame_end %0b",
                 $time, tx_byte, frame_end);
        mismatch_cnt++;
      end else begin
        want = due_bytes_q.pop_front();
        if (tx_byte !== want.tx) begin
          $display("%0t: tx_byte mismatch, expected %02h actual %02h", $time, want.tx, tx_byte);
          mismatch_cnt++;
        end
        if (frame_end !== want.last) begin
          $display("%0t: frame_end mismatch, expected %0b actual %0b",
                   $time, want.last, frame_end);
          mismatch_cnt++;
        end
      end
    end
  end

  // stimulus helpers
  task automatic add_start(logic st, logic [6:0] len, logic rw, logic [6:0] cmd);
    host_items_q.push_back('{func: csfb_pkg::FuncStart, st: st, len: len, rw: rw, cmd: cmd,
                             data: 8'($urandom)});
  endtask

  task automatic add_payload(logic [7:0] b);
    host_items_q.push_back('{func: csfb_pkg::FuncPayload, st: 1'($urandom), len: 7'($urandom),
                             rw: 1'($urandom), cmd: 7'($urandom), data: b});
  endtask

  task automatic add_frame(logic [6:0] len);
    add_start(1'($urandom), len, 1'($urandom), 7'($urandom));
    for (int i = 1; i < len; i++) add_payload(8'($urandom));
  endtask

  task automatic write_reg(logic [csfb_pkg::CfgIndexWidth-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    n_reg_writes++;
    if (idx == csfb_pkg::CfgMasterId) master_id_m = val;
    else if (idx == csfb_pkg::CfgSlaveId) slave_id_m = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until everything offered is taken and every expected byte is out
  task automatic drain();
    while (host_items_q.size() != 0 || due_bytes_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // mostly well-formed frames, some truncated frames, stray and surplus bytes
  task automatic queue_random_traffic(int n);
    int added;
    int roll;
    int len;
    int k;
    added = 0;
    while (added < n) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        roll = $urandom_range(99);
        if (roll < 80) len = $urandom_range(1, 8);
        else if (roll < 97) len = $urandom_range(9, 24);
        else len = $urandom_range(0, 40);
        add_frame(7'(len));
        added += (len > 1) ? len : 1;
      end else if (roll < 78) begin
        // frame cut short, the next start abandons it
        len = $urandom_range(3, 12);
        k = $urandom_range(0, len - 2);
        add_start(1'($urandom), 7'(len), 1'($urandom), 7'($urandom));
        for (int i = 0; i < k; i++) add_payload(8'($urandom));
        added += k + 1;
      end else if (roll < 88) begin
        // loose payload bytes
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) add_payload(8'($urandom));
        added += k;
      end else begin
        // empty frame, then bytes beyond the length
        add_frame(7'($urandom_range(0, 1)));
        added++;
        k = $urandom_range(0, 2);
        for (int i = 0; i < k; i++) add_payload(8'($urandom));
        added += k;
      end
    end
  endtask

  // run control
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed items with ids at their reset value
    add_start(1'b0, 7'd1, 1'b0, 7'd0);
    add_start(1'b1, 7'd0, 1'b1, 7'h7F);
    add_payload(8'hFF);
    add_start(1'b1, 7'd3, 1'b0, 7'h55);
    add_payload(8'h00);
    add_payload(8'hFF);
    add_payload(8'hA5);
    add_start(1'b0, 7'd5, 1'b1, 7'h2A);
    add_payload(8'h12);
    add_start(1'b0, 7'd2, 1'b1, 7'h7F);
    add_payload(8'h80);
    add_start(1'b1, 7'd127, 1'b1, 7'h00);
    add_payload(8'h01);
    add_start(1'b0, 7'd1, 1'b0, 7'h01);
    add_start(1'b1, 7'd4, 1'b0, 7'h40);
    add_payload(8'h7F);
    add_payload(8'hFE);
    add_payload(8'h3C);
    drain();

    // ids at maximum, unused indexes written too; sender idles
    write_reg(csfb_pkg::CfgMasterId, 8'hFF);
    write_reg(csfb_pkg::CfgSlaveId, 8'hFF);
    write_reg(CfgUnusedLow, 8'h5A);
    write_reg(CfgUnusedHigh, 8'hC3);
    send_idle_pct = 76;
    recv_stall_pct = 0;
    queue_random_traffic(25);
    drain();

    // random ids; receiver stalls and holds off long enough to back up the block
    write_reg(csfb_pkg::CfgMasterId, 8'($urandom));
    write_reg(csfb_pkg::CfgSlaveId, 8'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 76;
    pressure_on = 1'b1;
    queue_random_traffic(25);
    drain();

    // ids at minimum and a single bit; both sides idle
    write_reg(csfb_pkg::CfgMasterId, 8'h00);
    write_reg(csfb_pkg::CfgSlaveId, 8'h80);
    send_idle_pct = 32;
    recv_stall_pct = 32;
    queue_random_traffic(25);
    drain();

    // full speed, including a frame of maximum length
    write_reg(csfb_pkg::CfgMasterId, 8'($urandom));
    write_reg(csfb_pkg::CfgSlaveId, 8'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_traffic(20);
    add_frame(7'd127);
    drain();

    if (due_bytes_q.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, due_bytes_q.size());
      mismatch_cnt++;
    end
    $display("run covered %0d frames closed and %0d bytes checked, %0d loose payload drops",
             n_frames, n_bytes, n_dropped);
    $display("register writes: %0d across five id settings, idle and stall mixes, one hold-off",
             n_reg_writes);
    if (mismatch_cnt == 0) begin
      $display("crc16_serial_frame_builder test passed");
    end else begin
      $display("crc16_serial_frame_builder test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("crc16_serial_frame_builder test failed");
    $finish;
  end

endmodule

FILE: crc16_serial_frame_builder.f
hw/rtl/csfb_pkg.sv
hw/rtl/csfb_front.sv
hw/rtl/csfb_cmdq.sv
hw/rtl/csfb_back.sv
hw/rtl/crc16_serial_frame_builder.sv
tb/tb.sv
